// File: rtl/sapq_pkg.sv
package sapq_pkg;

    // default number of entries
    localparam int DEPTH_DEF = 16;

    // action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // value returned by a remove on an empty queue
    localparam logic signed [31:0] EMPTY_VALUE = -32'sd999;

    // one input item
    typedef struct packed {
        logic               action;
        logic signed [31:0] item_value;
        logic        [7:0]  item_priority;
    } cmd_t;

    // one result item
    typedef struct packed {
        logic signed [31:0] head_value;
        logic        [1:0]  status;
        logic               now_empty;
        logic               now_full;
    } result_t;

    // one stored entry
    typedef struct packed {
        logic signed [31:0] value;
        logic        [7:0]  prio;
    } entry_t;

    // control broadcast to every cell
    typedef struct packed {
        logic       insert;
        logic       remove;
        logic       front;
        logic [7:0] new_priority;
    } cell_ctrl_t;

endpackage

// File: rtl/sapq_cell.sv
module sapq_cell
    import sapq_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  logic       valid,
    input  entry_t     new_entry,
    input  entry_t     left_entry,
    input  entry_t     right_entry,
    input  logic       left_ahead,
    output logic       ahead,
    output entry_t     entry
);

    entry_t entry_reg;
    entry_t entry_next;

    // new item belongs at or ahead of this slot
    assign ahead = !valid || ctrl.front || (entry_reg.prio > ctrl.new_priority);

    // pick next contents: hold, take new, shift back or shift forward
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.insert && ahead)
        begin
            entry_next = left_ahead ? left_entry : new_entry;
        end
        else if (ctrl.remove)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

// File: rtl/sorted_array_priority_queue_unit.sv
// Sorted minimum-priority queue built as a row of DEPTH cells, each holding one
// value and priority pair; the head sits in cell 0. Every cell compares the new
// priority in parallel and shifts toward its neighbor, so one item is taken in
// every clock cycle and busy stays low. The result of each item appears on
// result, marked by done, in the cycle after start; it must be captured in
// that cycle since the block cannot hold it.
module sorted_array_priority_queue_unit
    import sapq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  cmd_t    cmd,
    output logic    done,
    output result_t result
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          done_reg;
    result_t       result_reg;
    result_t       result_next;

    entry_t     entries [DEPTH];
    logic       aheads  [DEPTH];
    cell_ctrl_t ctrl;
    entry_t     new_entry;
    logic       is_full;
    logic       is_empty;
    logic       do_ins;
    logic       do_rem;

    assign busy     = 1'b0;
    assign is_full  = (count_reg == FULL_COUNT);
    assign is_empty = (count_reg == '0);
    assign do_ins   = start && (cmd.action == ACT_INSERT) && !is_full;
    assign do_rem   = start && (cmd.action == ACT_REMOVE) && !is_empty;

    assign new_entry.value = cmd.item_value;
    assign new_entry.prio  = cmd.item_priority;

    // broadcast control; a tie with the head goes in front
    assign ctrl.insert       = do_ins;
    assign ctrl.remove       = do_rem;
    assign ctrl.front        = is_empty || (cmd.item_priority <= entries[0].prio);
    assign ctrl.new_priority = cmd.item_priority;

    // row of cells
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        localparam logic [CW-1:0] IDX = CW'(i);
        entry_t left_e;
        entry_t right_e;
        logic   left_b;

        if (i == 0)
        begin : g_first
            assign left_e = new_entry;
            assign left_b = 1'b0;
        end
        else
        begin : g_mid
            assign left_e = entries[i-1];
            assign left_b = aheads[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_e = entries[i];
        end
        else
        begin : g_inner
            assign right_e = entries[i+1];
        end

        sapq_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .valid       (IDX < count_reg),
            .new_entry   (new_entry),
            .left_entry  (left_e),
            .right_entry (right_e),
            .left_ahead  (left_b),
            .ahead       (aheads[i]),
            .entry       (entries[i])
        );
    end

    // occupancy and result formation
    always_comb
    begin
        count_next = count_reg;
        if (do_ins)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rem)
        begin
            count_next = count_reg - 1'b1;
        end

        result_next.head_value = '0;
        result_next.status     = ST_OK;
        if (cmd.action == ACT_INSERT)
        begin
            if (is_full)
            begin
                result_next.status = ST_FULL;
            end
        end
        else if (is_empty)
        begin
            result_next.head_value = EMPTY_VALUE;
            result_next.status     = ST_EMPTY;
        end
        else
        begin
            result_next.head_value = entries[0].value;
        end
        result_next.now_empty = (count_next == '0);
        result_next.now_full  = (count_next == FULL_COUNT);
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= start;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
